// ----- hdl/tridiagonal_solver_unit_assert.svh -----
// Assertion macros for the tridiagonal solver unit.
`ifndef TRIDIAGONAL_SOLVER_UNIT_ASSERT_SVH
`define TRIDIAGONAL_SOLVER_UNIT_ASSERT_SVH
// Implication checked every clock, disabled in reset.
`define TSU_ASSERT_IMP(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Next-cycle implication, disabled in reset.
`define TSU_ASSERT_NEXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// ----- hdl/tds_pkg.sv -----
// Package: types, constants and fixed-point helpers for the tridiagonal solver.
package tds_pkg;
   localparam int MAX_ROWS  = 64;
   localparam int FRAC_BITS = 16;
   localparam int IDX_W     = $clog2(MAX_ROWS);
   localparam int CNT_W     = $clog2(MAX_ROWS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ROWS - 1);
   localparam int QW        = 32;
   localparam int DIV_W     = QW + FRAC_BITS;
   localparam logic signed [QW-1:0] Q_MAX = 32'sh7fffffff;
   localparam logic signed [QW-1:0] Q_MIN = 32'sh80000000;

   typedef struct packed {
      logic signed [31:0] sub_diag;
      logic signed [31:0] main_diag;
      logic signed [31:0] super_diag;
      logic signed [31:0] right_side;
      logic               last_row;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] solution_value;
      logic [5:0]         element_index;
      logic               singular;
      logic               final_element;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_ADD, ST_DIV_A, ST_WAIT_A, ST_DIV_B, ST_WAIT_B,
      ST_STORE, ST_RD, ST_BMUL, ST_BADD, ST_EMIT
   } state_type;

   // Datapath operation selected by the controller.
   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_FMUL, OP_FADD, OP_DIVA, OP_DIVB, OP_STORE,
      OP_RDCOEF, OP_BMUL, OP_BADD, OP_NEXT, OP_DONE
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic is_last;
      logic first_row;
      logic at_zero;
   } status_type;

   function automatic logic signed [QW-1:0] sat32(input logic signed [65:0] v);
      if (v > 66'(signed'(Q_MAX))) return Q_MAX;
      if (v < 66'(signed'(Q_MIN))) return Q_MIN;
      return v[QW-1:0];
   endfunction

   // Rounded Q product from an exact 64-bit product.
   function automatic logic signed [QW-1:0] qround(input logic signed [63:0] p);
      logic signed [65:0] s;
      s = (66'(p) + 66'(64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      return sat32(s);
   endfunction
endpackage

// ----- hdl/tds_divider.sv -----
// Restoring divider for signed Q quotients with saturation and zero-pivot handling.
module tds_divider import tds_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [QW-1:0] num,
   input  logic signed [QW-1:0] den,
   input  logic                 flip,
   output logic                 busy,
   output logic                 zero_den,
   output logic signed [QW-1:0] quot
);
   localparam int STEP_W = $clog2(DIV_W + 1);
   logic [DIV_W-1:0]  rem_ff, rem_in, dvd_ff, dvd_in;
   logic [QW-1:0]     dvs_ff, dvs_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in, neg_ff, neg_in, zero_ff, zero_in, nz_ff, nz_in;
   logic [DIV_W:0]    trial;
   logic [DIV_W-1:0]  q;

   always_comb begin
      rem_in = rem_ff; dvd_in = dvd_ff; dvs_in = dvs_ff; step_in = step_ff;
      busy_in = busy_ff; neg_in = neg_ff; zero_in = zero_ff; nz_in = nz_ff;
      trial = {rem_ff, dvd_ff[DIV_W-1]} - {{(DIV_W-QW+1){1'b0}}, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DIV_W);
         rem_in  = '0;
         dvd_in  = {(num[QW-1] ? QW'(-num) : QW'(num)), {FRAC_BITS{1'b0}}};
         dvs_in  = den[QW-1] ? QW'(-den) : QW'(den);
         zero_in = (den == '0);
         nz_in   = (num != '0);
         neg_in  = (den == '0) ? (num[QW-1] != flip)
                               : ((num[QW-1] != den[QW-1]) != flip);
      end else if (busy_ff) begin
         // one quotient bit a cycle; quotient bits shift into the dividend
         if (!trial[DIV_W]) rem_in = trial[DIV_W-1:0];
         else rem_in = {rem_ff[DIV_W-2:0], dvd_ff[DIV_W-1]};
         dvd_in = {dvd_ff[DIV_W-2:0], ~trial[DIV_W]};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in; dvd_ff <= dvd_in; dvs_ff <= dvs_in;
      neg_ff <= neg_in; zero_ff <= zero_in; nz_ff <= nz_in;
   end

   // result formatting with saturation
   always_comb begin
      q = dvd_ff;
      if (zero_ff) quot = !nz_ff ? '0 : (neg_ff ? Q_MIN : Q_MAX);
      else if (neg_ff) quot = (q > DIV_W'(33'h80000000)) ? Q_MIN : QW'(-q);
      else quot = (q > DIV_W'(32'h7fffffff)) ? Q_MAX : q[QW-1:0];
   end
   assign busy = busy_ff;
   assign zero_den = zero_ff;
endmodule

// ----- hdl/tds_datapath.sv -----
// Datapath: row registers, coefficient memories, multiplier, adder and divider.
module tds_datapath import tds_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   input  req_word_type req_word,
   output status_type   status,
   output rsp_word_type rsp_data
);
   logic signed [QW-1:0] ratio_mem [MAX_ROWS];
   logic signed [QW-1:0] offset_mem [MAX_ROWS];
   logic signed [QW-1:0] l_ff, d_ff, u_ff, r_ff, ra_ff, ob_ff;
   logic signed [QW-1:0] piv_ff, num_ff, x_ff, acoef_ff;
   logic signed [63:0]   prod_a_ff, prod_b_ff;
   logic [IDX_W-1:0]     row_ff, idx_ff;
   logic                 last_ff, sing_ff, row_zero_ff;
   logic                 div_start, div_busy, div_zero;
   logic signed [QW-1:0] div_num, div_den, div_q;
   logic                 div_flip;
   logic [IDX_W-1:0]     prev_idx;

   assign prev_idx = row_ff - 1'b1;
   assign div_start = (cmd.op == OP_DIVA) || (cmd.op == OP_DIVB);
   assign div_num = (cmd.op == OP_DIVA) ? u_ff : num_ff;
   assign div_den = piv_ff;
   assign div_flip = (cmd.op == OP_DIVA);

   tds_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num), .den(div_den),
      .flip(div_flip), .busy(div_busy), .zero_den(div_zero), .quot(div_q)
   );

   // control-like registers: row counter, first-row and last-row flags, and singular flag
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         row_zero_ff <= 1'b1;
         sing_ff <= 1'b0;
         last_ff <= 1'b0;
      end else begin
         case (cmd.op)
            OP_LOAD: last_ff <= req_word.last_row || (row_ff == LAST_IDX);
            OP_DIVA, OP_DIVB: ;
            OP_STORE: begin
               if (div_zero) sing_ff <= 1'b1;
               if (!last_ff) begin
                  row_ff <= row_ff + 1'b1;
                  row_zero_ff <= 1'b0;
               end
            end
            OP_DONE: begin
               row_ff <= '0;
               row_zero_ff <= 1'b1;
               sing_ff <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   // payload registers and memories
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            l_ff <= req_word.sub_diag; d_ff <= req_word.main_diag;
            u_ff <= req_word.super_diag; r_ff <= req_word.right_side;
            ra_ff <= ratio_mem[prev_idx]; ob_ff <= offset_mem[prev_idx];
         end
         OP_FMUL: begin
            prod_a_ff <= 64'(l_ff) * 64'(ra_ff);
            prod_b_ff <= 64'(l_ff) * 64'(ob_ff);
         end
         OP_FADD: begin
            piv_ff <= row_zero_ff ? d_ff : sat32(66'(d_ff) + 66'(qround(prod_a_ff)));
            num_ff <= row_zero_ff ? r_ff : sat32(66'(r_ff) - 66'(qround(prod_b_ff)));
         end
         OP_STORE: begin
            if (last_ff) begin
               x_ff <= div_q;
               idx_ff <= row_ff;
            end else begin
               offset_mem[row_ff] <= div_q;
            end
         end
         OP_RDCOEF: begin
            acoef_ff <= ratio_mem[idx_ff];
            ob_ff <= offset_mem[idx_ff];
         end
         OP_BMUL: prod_a_ff <= 64'(acoef_ff) * 64'(x_ff);
         OP_BADD: x_ff <= sat32(66'(qround(prod_a_ff)) + 66'(ob_ff));
         OP_NEXT: idx_ff <= idx_ff - 1'b1;
         default: ;
      endcase
      // ratio is stored right after its divide finishes
      if (cmd.op == OP_DIVB && !last_ff) ratio_mem[row_ff] <= div_q;
   end

   assign status.div_busy = div_busy;
   assign status.is_last = last_ff;
   assign status.first_row = row_zero_ff;
   assign status.at_zero = (idx_ff == '0);
   assign rsp_data.solution_value = x_ff;
   assign rsp_data.element_index = 6'(idx_ff);
   assign rsp_data.singular = sing_ff;
   assign rsp_data.final_element = (idx_ff == '0);
endmodule

// ----- hdl/tds_controller.sv -----
// Controller: sequences forward sweep and back substitution.
module tds_controller import tds_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);
   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_MUL;
         ST_MUL:    state_in = ST_ADD;
         ST_ADD:    state_in = status.is_last ? ST_DIV_B : ST_DIV_A;
         ST_DIV_A:  state_in = ST_WAIT_A;
         ST_WAIT_A: if (!status.div_busy) state_in = ST_DIV_B;
         ST_DIV_B:  state_in = ST_WAIT_B;
         ST_WAIT_B: if (!status.div_busy) state_in = ST_STORE;
         ST_STORE:  state_in = status.is_last ? ST_EMIT : ST_IDLE;
         ST_EMIT: begin
            if (rsp_ready) state_in = status.at_zero ? ST_IDLE : ST_RD;
         end
         ST_RD:     state_in = ST_BMUL;
         ST_BMUL:   state_in = ST_BADD;
         ST_BADD:   state_in = ST_EMIT;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd.op = OP_NONE;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_LOAD;
         end
         ST_MUL:   cmd.op = OP_FMUL;
         ST_ADD:   cmd.op = OP_FADD;
         ST_DIV_A: cmd.op = OP_DIVA;
         ST_DIV_B: cmd.op = OP_DIVB;
         ST_STORE: cmd.op = OP_STORE;
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) cmd.op = status.at_zero ? OP_DONE : OP_NEXT;
         end
         ST_RD:    cmd.op = OP_RDCOEF;
         ST_BMUL:  cmd.op = OP_BMUL;
         ST_BADD:  cmd.op = OP_BADD;
         default:  cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

`include "tridiagonal_solver_unit_assert.svh"
   `TSU_ASSERT_IMP(a_no_both, clock, reset, req_ready, !rsp_valid, "ready during emit")
   `TSU_ASSERT_NEXT(a_div_start, clock, reset, state_ff == ST_DIV_A, status.div_busy, "divider idle")
   `TSU_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "valid dropped")
endmodule

// ----- hdl/tridiagonal_solver_unit.sv -----
// Top level of the tridiagonal solver unit.
// Takes one matrix row per word; each row runs a restoring divide per
// coefficient (two per non-last row, one on the last) on the shared
// bit-serial divider. After the last row, the solution words come out from
// the highest index down to 0, each lower word after the coefficient read,
// multiply and add of back substitution, and each held until rsp_ready. No
// input is taken while results are pending.
module tridiagonal_solver_unit import tds_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);
   cmd_type    cmd;
   status_type status;

   tds_controller u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .status(status), .cmd(cmd)
   );

   tds_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req_word(req_word),
      .status(status), .rsp_data(rsp_word)
   );
endmodule

// ----- test/tridiagonal_solver_checker.sv -----
// Checker for the tridiagonal solver unit: predicts solution words and compares them.
module tridiagonal_solver_checker import tds_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_word_type req_word,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_word_type rsp_word,
   output int           fail_count,
   output int           pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic signed [31:0] ratio_mem [MAX_ROWS];
   logic signed [31:0] offset_mem [MAX_ROWS];
   int                 rows_taken;
   bit                 pivot_zero_seen;
   rsp_word_type       solution_queue [$];

   initial fail_count = 0;
   assign pending_count = solution_queue.size();

   function automatic logic signed [31:0] clamp_q(input longint v);
      if (v > longint'(Q_MAX)) return Q_MAX;
      if (v < longint'(Q_MIN)) return Q_MIN;
      return v[31:0];
   endfunction

   // Rounded fixed-point product, round half up.
   function automatic logic signed [31:0] fix_mul(input logic signed [31:0] x,
                                                  input logic signed [31:0] y);
      longint p;
      p = longint'(x) * longint'(y) + (longint'(1) << (FRAC_BITS - 1));
      return clamp_q(p >>> FRAC_BITS);
   endfunction

   // Fixed-point quotient, truncated toward zero; flip negates.
   function automatic logic signed [31:0] fix_div(input logic signed [31:0] num,
                                                  input logic signed [31:0] den,
                                                  input bit flip);
      bit                neg;
      longint unsigned   un, ud, q;
      if (den == 0) begin
         pivot_zero_seen = 1;
         if (num == 0) return 0;
         return ((num < 0) != flip) ? Q_MIN : Q_MAX;
      end
      neg = ((num < 0) != (den < 0)) != flip;
      un = (num < 0) ? longint'(-longint'(num)) : longint'(num);
      ud = (den < 0) ? longint'(-longint'(den)) : longint'(den);
      q = (un << FRAC_BITS) / ud;
      if (neg) return (q > 64'h8000_0000) ? Q_MIN : clamp_q(-longint'(q));
      return (q > 64'h7fff_ffff) ? Q_MAX : q[31:0];
   endfunction

   // Forward sweep for one row; back substitution on the last.
   task automatic solve_row(input req_word_type w);
      int                 i, k;
      bit                 last;
      logic signed [31:0] pivot, numer, x;
      rsp_word_type       s;
      i = (rows_taken >= MAX_ROWS) ? MAX_ROWS - 1 : rows_taken;
      last = w.last_row || (i == MAX_ROWS - 1);
      if (i == 0) begin
         pivot = w.main_diag;
         numer = w.right_side;
      end else begin
         pivot = clamp_q(longint'(w.main_diag) + fix_mul(w.sub_diag, ratio_mem[i-1]));
         numer = clamp_q(longint'(w.right_side) - fix_mul(w.sub_diag, offset_mem[i-1]));
      end
      if (!last) begin
         ratio_mem[i] = fix_div(w.super_diag, pivot, 1);
         offset_mem[i] = fix_div(numer, pivot, 0);
         rows_taken = i + 1;
         return;
      end
      x = fix_div(numer, pivot, 0);
      for (k = i; k >= 0; k--) begin
         if (k != i)
            x = clamp_q(longint'(fix_mul(ratio_mem[k], x)) + offset_mem[k]);
         s.solution_value = x;
         s.element_index = 6'(k);
         s.singular = pivot_zero_seen;
         s.final_element = (k == 0);
         solution_queue.push_back(s);
      end
      rows_taken = 0;
      pivot_zero_seen = 0;
   endtask

   task automatic report(input string what, input int got, input int want);
      $display("%0t: mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_word_type e;
      if (reset) begin
         rows_taken = 0;
         pivot_zero_seen = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (solution_queue.size() == 0) begin
               report("unexpected word index", rsp_word.element_index, -1);
            end else begin
               e = solution_queue.pop_front();
               if (rsp_word.solution_value !== e.solution_value)
                  report("solution_value", rsp_word.solution_value, e.solution_value);
               if (rsp_word.element_index !== e.element_index)
                  report("element_index", rsp_word.element_index, e.element_index);
               if (rsp_word.singular !== e.singular)
                  report("singular", rsp_word.singular, e.singular);
               if (rsp_word.final_element !== e.final_element)
                  report("final_element", rsp_word.final_element, e.final_element);
            end
         end
         if (req_valid && req_ready) solve_row(req_word);
      end
   end
endmodule

// ----- test/tb.sv -----
// Testbench top for the tridiagonal solver unit: stimulus, stalls and verdict.
module tb;
   import tds_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 20000;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_valid = 0;
   logic         req_ready;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_ready = 0;
   rsp_word_type rsp_word;
   int           fail_count, pending_count;
   int           idle_cycles;
   bit           quiet_phase = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   tridiagonal_solver_unit DUT (.*);

   tridiagonal_solver_checker checker_i (
      .clock, .reset, .req_valid, .req_ready, .req_word,
      .rsp_valid, .rsp_ready, .rsp_word, .fail_count, .pending_count);

   // Watchdog: cycles without any accepted word.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > STALL_LIMIT) begin
            $display("tridiagonal_solver_unit verification failed");
            $finish;
         end
      end
   end

   // Result side: random stall bursts.
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 17);
            rsp_ready <= 0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1;
      end
   end

   function automatic logic signed [31:0] pick_value(input int mode);
      case (mode)
         0: return $urandom;
         1: return 32'sh7fffffff;
         2: return 32'sh80000000;
         3: return 0;
         default: return $signed(32'($urandom_range(0, 32'h4_0000))) - 32'sh2_0000;
      endcase
   endfunction

   // Valid stays high from one word to the next unless an idle burst comes.
   task automatic send_row(input req_word_type w);
      int n;
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 17);
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1;
      req_word <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   // A system of size rows; dominant diagonal unless wild is set.
   task automatic send_system(input int size, input bit wild);
      req_word_type w;
      for (int r = 0; r < size; r++) begin
         w.sub_diag = wild ? pick_value($urandom_range(0, 4)) : pick_value(4);
         w.super_diag = wild ? pick_value($urandom_range(0, 4)) : pick_value(4);
         w.main_diag = wild ? pick_value($urandom_range(0, 4))
                            : 32'sh8_0000 + $signed(32'($urandom_range(0, 32'h8_0000)));
         if (!wild && $urandom_range(0, 1)) w.main_diag = -w.main_diag;
         w.right_side = pick_value($urandom_range(0, 4));
         w.last_row = (r == size - 1);
         send_row(w);
      end
   endtask

   initial begin
      int sent;
      req_word_type w;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: one-row systems at extremes, zero pivots, signed zero numerator.
      send_row('{32'sh7fffffff, 32'sh0001_0000, 32'sh80000000, 32'sh7fffffff, 1'b1});
      send_row('{32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1'b1});
      send_row('{0, 0, 0, 32'sh0001_0000, 1'b1});
      send_row('{0, 0, 0, 32'shffff_0000, 1'b1});
      send_row('{0, 0, 0, 0, 1'b1});
      send_row('{32'sh7fffffff, 32'sh0000_0001, 32'sh7fffffff, 32'sh7fffffff, 1'b1});
      // Zero pivot on an inner row, then saturating coefficients.
      send_row('{0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0002_0000, 1'b0});
      send_row('{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0003_0000, 1'b0});
      send_row('{32'sh7fffffff, 32'sh80000000, 0, 32'sh7fffffff, 1'b1});
      send_system(3, 1);
      // Pause until every solution word has come.
      req_valid <= 0;
      @(negedge clock);
      wait (pending_count == 0);
      @(posedge clock);
      // Full-size run: last_row never set, run closes at the top index.
      w = '0;
      for (int r = 0; r < MAX_ROWS; r++) begin
         w.main_diag = 32'sh0004_0000;
         w.sub_diag = 32'sh0001_0000;
         w.super_diag = 32'shffff_0000;
         w.right_side = $urandom;
         send_row(w);
      end
      sent = 9 + 3 + MAX_ROWS;
      // Random systems: mostly small, well formed.
      while (sent < 250) begin
         int size;
         size = ($urandom_range(0, 15) == 0) ? $urandom_range(20, MAX_ROWS)
                                             : $urandom_range(1, 6);
         if (sent > 220) quiet_phase = 1;
         send_system(size, $urandom_range(0, 4) == 0);
         sent += size;
      end
      quiet_phase = 1;
      req_valid <= 0;
      @(negedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("tridiagonal_solver_unit verification clean");
      else
         $display("tridiagonal_solver_unit verification failed");
      $finish;
   end
endmodule
